### design/tssr_pkg.sv
`timescale 1ns / 1ps

package tssr_pkg;

  // ring geometry
  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // field widths
  localparam int CMD_W    = 2;
  localparam int CLK_W    = 4;
  localparam int ACC_W    = 9;
  localparam int PERIOD_W = 8;
  localparam int SAMPLE_W = 8;

  // configuration port
  localparam int  CFG_ADDR_W     = 3;
  localparam int  CFG_DATA_W     = 32;
  localparam logic REG_IDX_PERIOD = 1'b0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // sample levels
  localparam logic [SAMPLE_W-1:0] LEVEL_HIGH_SAMPLE = 8'd255;
  localparam logic [SAMPLE_W-1:0] LEVEL_LOW_SAMPLE  = 8'd127;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic toggle;
    logic tick_add;
    logic tick_write;
    logic rd_issue;
    logic rd_finish;
  } tssr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic acc_ge;
    logic out_busy;
  } tssr_status_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    logic [PTR_W-1:0] nxt;
    nxt = pos + 1'b1;
    if (pos == PTR_W'(RING_DEPTH - 1)) begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

### design/tssr_ctrl.sv
`timescale 1ns / 1ps

module tssr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic [tssr_pkg::CMD_W-1:0]   command,
  output logic                         s_tready,
  input  tssr_pkg::tssr_status_t       status,
  output tssr_pkg::tssr_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_READ
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (command)
            tssr_pkg::CMD_TOGGLE: begin
              cmd.toggle = 1'b1;
            end
            tssr_pkg::CMD_TICK: begin
              cmd.tick_add = 1'b1;
              state_next   = ST_TICK;
            end
            tssr_pkg::CMD_READ: begin
              cmd.rd_issue = 1'b1;
              state_next   = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        // one ring write per cycle until the accumulator is below a period
        if (status.acc_ge) begin
          cmd.tick_write = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (!status.out_busy) begin
          cmd.rd_finish = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/tssr_datapath.sv
`timescale 1ns / 1ps

module tssr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  tssr_pkg::tssr_cmd_t             cmd,
  output tssr_pkg::tssr_status_t          status,
  input  logic [tssr_pkg::CLK_W-1:0]      tick_clocks,
  input  logic                            batch_start,
  input  logic                            cfg_we,
  input  logic [tssr_pkg::PERIOD_W-1:0]   cfg_wdata,
  output logic [tssr_pkg::PERIOD_W-1:0]   cfg_period,
  output logic                            out_valid,
  output logic [tssr_pkg::SAMPLE_W-1:0]   out_sample,
  input  logic                            out_ready
);

  logic [tssr_pkg::SAMPLE_W-1:0] mem [tssr_pkg::RING_DEPTH];

  logic                          level;
  logic [tssr_pkg::ACC_W-1:0]    acc;
  logic [tssr_pkg::PTR_W-1:0]    wp;
  logic [tssr_pkg::PTR_W-1:0]    rp;
  logic [tssr_pkg::PTR_W-1:0]    clr_addr;
  logic [tssr_pkg::SAMPLE_W-1:0] quiet;
  logic [tssr_pkg::PERIOD_W-1:0] period_reg;
  logic [tssr_pkg::SAMPLE_W-1:0] rdata;
  logic                          batch_q;

  logic [tssr_pkg::PERIOD_W-1:0] period;
  logic [tssr_pkg::ACC_W-1:0]    period_ext;
  logic [tssr_pkg::PTR_W-1:0]    rp_next;
  logic [tssr_pkg::SAMPLE_W-1:0] tick_sample;
  logic [tssr_pkg::SAMPLE_W-1:0] fill_sample;

  // a zero period acts as one
  assign period      = (period_reg == '0) ? tssr_pkg::PERIOD_W'(1) : period_reg;
  assign period_ext  = tssr_pkg::ACC_W'(period);
  assign rp_next     = tssr_pkg::ring_next(rp);
  assign tick_sample = level ? tssr_pkg::LEVEL_HIGH_SAMPLE : tssr_pkg::LEVEL_LOW_SAMPLE;
  assign fill_sample = batch_q ? rdata : quiet;

  assign status.clr_last = (clr_addr == tssr_pkg::PTR_W'(tssr_pkg::RING_DEPTH - 1));
  assign status.acc_ge   = (acc >= period_ext);
  assign status.out_busy = out_valid && !out_ready;
  assign cfg_period      = period_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= 1'b0;
      acc        <= '0;
      wp         <= '0;
      rp         <= '0;
      clr_addr   <= '0;
      quiet      <= tssr_pkg::LEVEL_LOW_SAMPLE;
      period_reg <= tssr_pkg::PERIOD_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_reg <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.toggle) begin
        level <= ~level;
      end
      if (cmd.tick_add) begin
        acc <= acc + tssr_pkg::ACC_W'(tick_clocks);
      end
      if (cmd.tick_write) begin
        acc <= acc - period_ext;
        wp  <= tssr_pkg::ring_next(wp);
      end
      if (cmd.rd_finish) begin
        out_valid <= 1'b1;
        if (batch_q) begin
          quiet <= rdata;
        end
        if (rp_next != wp) begin
          rp <= rp_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      batch_q <= batch_start;
    end
    if (cmd.rd_finish) begin
      out_sample <= rdata;
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= tssr_pkg::LEVEL_LOW_SAMPLE;
    end else if (cmd.tick_write) begin
      mem[wp] <= tick_sample;
    end else if (cmd.rd_finish) begin
      mem[rp] <= fill_sample;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[rp];
    end
  end

endmodule

### design/toggle_speaker_sample_ring.sv
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser[1:0] command;
//                                   s_tdata[3:0] tick_clocks, [4] batch_start
// m_*       out  m_tvalid/m_tready  m_tdata[7:0] sample
// apb       in   psel/penable/pwr   0x0 cpu_clocks_per_sample (8 bits, reset 1)
//
// toggle completes on acceptance; read is a registered ring read, then write-back
// tick adds tick_clocks to the accumulator, then one ring write per cycle while it holds a period
// after rst the ring is swept to 127, one entry a cycle over all 1024 entries, no
// item accepted meanwhile
// a read waits after its ring read while the previous sample is untaken

module toggle_speaker_sample_ring (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // tick_clocks[3:0], batch_start[4]
  input  logic [tssr_pkg::CMD_W-1:0]        s_tuser,  // command[1:0]
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,  // sample[7:0]
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tssr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tssr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tssr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  tssr_pkg::tssr_cmd_t              cmd;
  tssr_pkg::tssr_status_t           status;
  logic                             cfg_we;
  logic                             reg_hit;
  logic [tssr_pkg::PERIOD_W-1:0]    cfg_period;

  // word-addressed register decode, bit 2 picks the register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tssr_pkg::REG_IDX_PERIOD);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? tssr_pkg::CFG_DATA_W'(cfg_period) : '0;

  // sequencer: clearing sweep, item dispatch, tick write loop, read finish
  tssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .command  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // ring memory, pointers, accumulator, speaker level, output register
  tssr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .tick_clocks (s_tdata[3:0]),
    .batch_start (s_tdata[4]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[tssr_pkg::PERIOD_W-1:0]),
    .cfg_period  (cfg_period),
    .out_valid   (m_tvalid),
    .out_sample  (m_tdata),
    .out_ready   (m_tready)
  );

endmodule
